FILE: hdl/owm_pkg.sv
`timescale 1ns / 1ps

package owm_pkg;

  localparam int TIME_W      = 12;
  localparam int CFG_IDX_W   = 3;
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  // Timing register defaults, in ticks
  localparam logic [TIME_W-1:0] RST_RESET_LOW     = 12'd480;
  localparam logic [TIME_W-1:0] RST_PRESENCE_SAMP = 12'd80;
  localparam logic [TIME_W-1:0] RST_RESET_TAIL    = 12'd400;
  localparam logic [TIME_W-1:0] RST_WRITE_ONE_LOW = 12'd1;
  localparam logic [TIME_W-1:0] RST_WRITE_SLOT    = 12'd50;
  localparam logic [TIME_W-1:0] RST_READ_LOW      = 12'd2;
  localparam logic [TIME_W-1:0] RST_READ_WAIT     = 12'd60;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RESET_LOW     = 3'd0,
    REG_PRESENCE_SAMP = 3'd1,
    REG_RESET_TAIL    = 3'd2,
    REG_WRITE_ONE_LOW = 3'd3,
    REG_WRITE_SLOT    = 3'd4,
    REG_READ_LOW      = 3'd5,
    REG_READ_WAIT     = 3'd6
  } reg_idx_t;

  typedef enum logic [1:0] {
    OP_NONE  = 2'd0,
    OP_RESET = 2'd1,
    OP_WRITE = 2'd2,
    OP_READ  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    PH_IDLE      = 3'd0,
    PH_RST_LOW   = 3'd1,
    PH_RST_REL   = 3'd2,
    PH_RST_TAIL  = 3'd3,
    PH_SLOT_LOW  = 3'd4,
    PH_SLOT_HIGH = 3'd5,
    PH_RECOVER   = 3'd6
  } phase_t;

  // One classified tick as it travels from front to back
  typedef struct packed {
    op_t        op;
    logic [7:0] tx_byte;
    logic       line_level;
  } tick_t;

  // Beat handshake between stages
  typedef struct packed {
    logic valid;
    logic ready;
  } hs_t;

endpackage

FILE: hdl/owm_front.sv
`timescale 1ns / 1ps

module owm_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        in_cmd,
  input  logic [7:0]        in_tx_byte,
  input  logic              in_line_level,
  output owm_pkg::tick_t    fr_tick,
  output logic              fr_valid,
  input  logic              fr_ready
);

  logic           valid_r, valid_nxt;
  owm_pkg::tick_t tick_r, tick_nxt;
  logic           accept;

  assign in_ready = !valid_r || fr_ready;
  assign accept   = in_valid && in_ready;

  // classify: decode command, keep tx byte only for writes
  always_comb begin
    tick_nxt            = tick_r;
    tick_nxt.op         = owm_pkg::op_t'(in_cmd);
    tick_nxt.line_level = in_line_level;
    tick_nxt.tx_byte    = (owm_pkg::op_t'(in_cmd) == owm_pkg::OP_WRITE) ? in_tx_byte : 8'd0;
  end

  always_comb begin
    valid_nxt = valid_r;
    if (accept) begin
      valid_nxt = 1'b1;
    end else if (fr_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      tick_r <= tick_nxt;
    end
  end

  assign fr_tick  = tick_r;
  assign fr_valid = valid_r;

endmodule

FILE: hdl/owm_queue.sv
`timescale 1ns / 1ps

module owm_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  owm_pkg::tick_t push_data,
  input  logic           push_valid,
  output logic           push_ready,
  output owm_pkg::tick_t pop_data,
  output logic           pop_valid,
  input  logic           pop_ready
);

  owm_pkg::tick_t                    mem_r [owm_pkg::QUEUE_DEPTH];
  logic [owm_pkg::QUEUE_PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [owm_pkg::QUEUE_PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [owm_pkg::QUEUE_CNT_W-1:0]   cnt_r, cnt_nxt;
  logic                              push, pop;

  assign push_ready = (cnt_r != owm_pkg::QUEUE_CNT_W'(owm_pkg::QUEUE_DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_data   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

FILE: hdl/owm_back.sv
`timescale 1ns / 1ps

module owm_back (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_wr_en,
  input  logic [owm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [owm_pkg::TIME_W-1:0]      cfg_data,
  input  owm_pkg::tick_t                  q_tick,
  input  logic                            q_valid,
  output logic                            q_pop,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            out_drive_low,
  output logic                            out_busy_res,
  output logic                            out_done_res,
  output logic                            out_presence,
  output logic [7:0]                      out_rx_byte
);

  localparam int TW = owm_pkg::TIME_W;

  // timing registers
  logic [TW-1:0] t_rst_low_r, t_pres_r, t_tail_r, t_w1_low_r, t_wslot_r, t_rd_low_r, t_rd_wait_r;

  // sequencer state
  owm_pkg::phase_t phase_r, phase_nxt, ph_cur;
  owm_pkg::op_t    op_r, op_cur;
  logic [TW-1:0]   tc_r, tc_nxt, tc_cur, cnt, lim;
  logic [2:0]      bi_r, bi_nxt, bi_cur;
  logic [7:0]      sh_r, sh_nxt, sh_cur;
  logic            pres_r, pres_nxt;
  logic [7:0]      rx_r, rx_nxt;
  logic            start, cur_bit, step_done;
  logic            drive_c, busy_c;

  // output register
  logic            ov_r, o_drive_r, o_busy_r, o_done_r, o_pres_r;
  logic [7:0]      o_rx_r;
  logic            fire;

  assign fire  = q_valid && (!ov_r || out_ready);
  assign q_pop = fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t_rst_low_r <= owm_pkg::RST_RESET_LOW;
      t_pres_r    <= owm_pkg::RST_PRESENCE_SAMP;
      t_tail_r    <= owm_pkg::RST_RESET_TAIL;
      t_w1_low_r  <= owm_pkg::RST_WRITE_ONE_LOW;
      t_wslot_r   <= owm_pkg::RST_WRITE_SLOT;
      t_rd_low_r  <= owm_pkg::RST_READ_LOW;
      t_rd_wait_r <= owm_pkg::RST_READ_WAIT;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        owm_pkg::REG_RESET_LOW:     t_rst_low_r <= cfg_data;
        owm_pkg::REG_PRESENCE_SAMP: t_pres_r    <= cfg_data;
        owm_pkg::REG_RESET_TAIL:    t_tail_r    <= cfg_data;
        owm_pkg::REG_WRITE_ONE_LOW: t_w1_low_r  <= cfg_data;
        owm_pkg::REG_WRITE_SLOT:    t_wslot_r   <= cfg_data;
        owm_pkg::REG_READ_LOW:      t_rd_low_r  <= cfg_data;
        owm_pkg::REG_READ_WAIT:     t_rd_wait_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // a command on an idle tick starts the operation in that same tick
  always_comb begin
    start  = (phase_r == owm_pkg::PH_IDLE) && (q_tick.op != owm_pkg::OP_NONE);
    ph_cur = phase_r;
    op_cur = op_r;
    tc_cur = tc_r;
    bi_cur = bi_r;
    sh_cur = sh_r;
    if (start) begin
      op_cur = q_tick.op;
      tc_cur = '0;
      bi_cur = '0;
      sh_cur = q_tick.tx_byte;
      ph_cur = (q_tick.op == owm_pkg::OP_RESET) ? owm_pkg::PH_RST_LOW : owm_pkg::PH_SLOT_LOW;
    end
    cur_bit = sh_cur[bi_cur];
    cnt     = tc_cur + 1'b1;
  end

  // next state
  always_comb begin
    phase_nxt = ph_cur;
    tc_nxt    = cnt;
    bi_nxt    = bi_cur;
    sh_nxt    = sh_cur;
    pres_nxt  = pres_r;
    rx_nxt    = rx_r;
    step_done = 1'b0;
    lim       = '0;
    case (ph_cur)
      owm_pkg::PH_IDLE: begin
        tc_nxt = tc_r;
      end
      owm_pkg::PH_RST_LOW: begin
        if (cnt >= t_rst_low_r) begin
          phase_nxt = owm_pkg::PH_RST_REL;
          tc_nxt    = '0;
        end
      end
      owm_pkg::PH_RST_REL: begin
        if (cnt >= t_pres_r) begin
          pres_nxt  = !q_tick.line_level;
          phase_nxt = owm_pkg::PH_RST_TAIL;
          tc_nxt    = '0;
        end
      end
      owm_pkg::PH_RST_TAIL: begin
        if (cnt >= t_tail_r) begin
          phase_nxt = owm_pkg::PH_IDLE;
          tc_nxt    = '0;
          step_done = 1'b1;
        end
      end
      owm_pkg::PH_SLOT_LOW: begin
        if (op_cur == owm_pkg::OP_READ) begin
          lim = t_rd_low_r;
        end else begin
          lim = cur_bit ? t_w1_low_r : t_wslot_r;
        end
        if (cnt >= lim) begin
          // write zero skips the released part of the slot
          if (op_cur == owm_pkg::OP_WRITE && !cur_bit) begin
            phase_nxt = owm_pkg::PH_RECOVER;
          end else begin
            phase_nxt = owm_pkg::PH_SLOT_HIGH;
          end
          tc_nxt = '0;
        end
      end
      owm_pkg::PH_SLOT_HIGH: begin
        if (op_cur == owm_pkg::OP_READ && tc_cur == '0) begin
          sh_nxt[bi_cur] = sh_cur[bi_cur] | q_tick.line_level;
        end
        lim = (op_cur == owm_pkg::OP_READ) ? t_rd_wait_r : t_wslot_r;
        if (cnt >= lim) begin
          phase_nxt = owm_pkg::PH_RECOVER;
          tc_nxt    = '0;
        end
      end
      owm_pkg::PH_RECOVER: begin
        tc_nxt = '0;
        if (bi_cur == 3'd7) begin
          phase_nxt = owm_pkg::PH_IDLE;
          step_done = 1'b1;
          if (op_cur == owm_pkg::OP_READ) begin
            rx_nxt = sh_cur;
          end
        end else begin
          bi_nxt    = bi_cur + 1'b1;
          phase_nxt = owm_pkg::PH_SLOT_LOW;
        end
      end
      default: begin
        phase_nxt = owm_pkg::PH_IDLE;
        tc_nxt    = tc_r;
      end
    endcase
  end

  // outputs
  always_comb begin
    busy_c  = (ph_cur != owm_pkg::PH_IDLE);
    drive_c = (ph_cur == owm_pkg::PH_RST_LOW) || (ph_cur == owm_pkg::PH_SLOT_LOW);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= owm_pkg::PH_IDLE;
      op_r    <= owm_pkg::OP_NONE;
      tc_r    <= '0;
      bi_r    <= '0;
      sh_r    <= '0;
      pres_r  <= 1'b0;
      rx_r    <= '0;
      ov_r    <= 1'b0;
    end else begin
      if (fire) begin
        phase_r <= phase_nxt;
        op_r    <= op_cur;
        tc_r    <= tc_nxt;
        bi_r    <= bi_nxt;
        sh_r    <= sh_nxt;
        pres_r  <= pres_nxt;
        rx_r    <= rx_nxt;
        ov_r    <= 1'b1;
      end else if (out_ready) begin
        ov_r    <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      o_drive_r <= drive_c;
      o_busy_r  <= busy_c;
      o_done_r  <= step_done;
      o_pres_r  <= pres_nxt;
      o_rx_r    <= rx_nxt;
    end
  end

  assign out_valid     = ov_r;
  assign out_drive_low = o_drive_r;
  assign out_busy_res  = o_busy_r;
  assign out_done_res  = o_done_r;
  assign out_presence  = o_pres_r;
  assign out_rx_byte   = o_rx_r;

endmodule

FILE: hdl/one_wire_master_top.sv
`timescale 1ns / 1ps

// Channel   Handshake            Payload
// in_       in_valid/in_ready    in_cmd[1:0], in_tx_byte[7:0], in_line_level
// out_      out_valid/out_ready  out_drive_low, out_busy_res, out_done_res,
//                                out_presence, out_rx_byte[7:0]
// cfg_      cfg_wr_en            cfg_index[2:0], cfg_data[11:0]
//
// One tick beat in and one result beat out per clock, sustained while out_ready stays high.
// An input beat passes the front register, the 4-deep tick queue and the sequencer
// output register on its way to out_.
// The sequencer advances one bus tick per popped beat; its next-state logic is combinational.
// Reset (rst_n low, synchronous) idles the sequencer, empties the queue and
// reloads the timing registers with their defaults.
// A stalled out_ready holds the sequencer; the queue and the front register then
// absorb up to five further input beats before in_ready drops.

module one_wire_master_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_cmd,
  input  logic [7:0]  in_tx_byte,
  input  logic        in_line_level,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_drive_low,
  output logic        out_busy_res,
  output logic        out_done_res,
  output logic        out_presence,
  output logic [7:0]  out_rx_byte,
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_index,
  input  logic [11:0] cfg_data
);

  owm_pkg::tick_t fr_tick, q_tick;
  logic           fr_valid, q_push_ready;
  logic           q_valid, q_pop;

  // front: registers and classifies each tick beat
  owm_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_cmd        (in_cmd),
    .in_tx_byte    (in_tx_byte),
    .in_line_level (in_line_level),
    .fr_tick       (fr_tick),
    .fr_valid      (fr_valid),
    .fr_ready      (q_push_ready)
  );

  // decoupling queue between front and sequencer
  owm_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_data  (fr_tick),
    .push_valid (fr_valid),
    .push_ready (q_push_ready),
    .pop_data   (q_tick),
    .pop_valid  (q_valid),
    .pop_ready  (q_pop)
  );

  // back: bus sequencer, timing registers and result register
  owm_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .q_tick        (q_tick),
    .q_valid       (q_valid),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_drive_low (out_drive_low),
    .out_busy_res  (out_busy_res),
    .out_done_res  (out_done_res),
    .out_presence  (out_presence),
    .out_rx_byte   (out_rx_byte)
  );

  // a completing tick is always a busy tick
  a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_done_res |-> out_busy_res)
    else $error("done without busy");

  // the bus is only pulled low during an operation
  a_drive_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_drive_low |-> out_busy_res)
    else $error("drive low while idle");

  // the sequencer only steps on a queued beat
  a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("pop from empty queue");

  // a front beat waiting on a full queue stays put
  a_front_hold: assert property (@(posedge clk) disable iff (!rst_n)
    fr_valid && !q_push_ready |=> fr_valid && $stable(fr_tick))
    else $error("front beat lost while queue full");

endmodule

FILE: sim/tb_one_wire_master_top.sv
`timescale 1ns / 1ps

module tb_one_wire_master_top;
  import owm_pkg::*;

  localparam logic [2:0] REG_UNUSED = 3'd7;  // past the last timing register
  localparam int LONG_HOLD = 64;             // receiver hold-off, fills the tick queue

  // Expected bus outputs for one tick
  typedef struct packed {
    logic       drive;
    logic       busy;
    logic       done;
    logic       pres;
    logic [7:0] rx;
  } bus_out_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_cmd = 2'd0;
  logic [7:0]  in_tx_byte = 8'd0;
  logic        in_line_level = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        out_drive_low;
  logic        out_busy_res;
  logic        out_done_res;
  logic        out_presence;
  logic [7:0]  out_rx_byte;
  logic        cfg_wr_en = 1'b0;
  logic [2:0]  cfg_index = 3'd0;
  logic [11:0] cfg_data = 12'd0;

  one_wire_master_top dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_cmd        (in_cmd),
    .in_tx_byte    (in_tx_byte),
    .in_line_level (in_line_level),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_drive_low (out_drive_low),
    .out_busy_res  (out_busy_res),
    .out_done_res  (out_done_res),
    .out_presence  (out_presence),
    .out_rx_byte   (out_rx_byte),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Bus sequencer mirror: timing registers plus sequencer state, stepped once
  // per accepted tick beat.
  // ---------------------------------------------------------------------------
  logic [11:0] tcfg [0:6];
  phase_t      sq_phase = PH_IDLE;
  op_t         sq_op = OP_NONE;
  logic [11:0] sq_cnt = '0;
  logic [2:0]  sq_bit = '0;
  logic [7:0]  sq_shift = '0;
  logic        sq_pres = 1'b0;
  logic [7:0]  sq_rx = '0;

  tick_t    bus_ticks_q [$];   // beats waiting for the driver
  bus_out_t bus_out_q [$];     // expected outputs, oldest first

  int  n_beats = 0;
  int  n_results = 0;
  int  n_errors = 0;
  int  n_done = 0;
  int  n_settings = 0;
  int  n_start [0:3];
  bit  calm = 1'b0;        // final stretch: no idling on either side
  bit  hold_req = 1'b0;
  bit  hold_done = 1'b0;

  initial begin
    tcfg[REG_RESET_LOW]     = RST_RESET_LOW;
    tcfg[REG_PRESENCE_SAMP] = RST_PRESENCE_SAMP;
    tcfg[REG_RESET_TAIL]    = RST_RESET_TAIL;
    tcfg[REG_WRITE_ONE_LOW] = RST_WRITE_ONE_LOW;
    tcfg[REG_WRITE_SLOT]    = RST_WRITE_SLOT;
    tcfg[REG_READ_LOW]      = RST_READ_LOW;
    tcfg[REG_READ_WAIT]     = RST_READ_WAIT;
    for (int i = 0; i < 4; i++) n_start[i] = 0;
  end

  function automatic bus_out_t step_bus_master(op_t cmd, logic [7:0] tx, logic line);
    bus_out_t    r;
    logic [11:0] cnt;
    logic [11:0] lim;
    logic        bit_now;
    r = '0;
    // a command only starts from idle; the start tick already runs the op
    if (sq_phase == PH_IDLE && cmd != OP_NONE) begin
      n_start[cmd]++;
      sq_op  = cmd;
      sq_cnt = '0;
      sq_bit = '0;
      if (cmd == OP_RESET) begin
        sq_phase = PH_RST_LOW;
      end else begin
        sq_phase = PH_SLOT_LOW;
        sq_shift = (cmd == OP_WRITE) ? tx : 8'h00;
      end
    end
    if (sq_phase != PH_IDLE) begin
      r.busy  = 1'b1;
      r.drive = (sq_phase == PH_RST_LOW || sq_phase == PH_SLOT_LOW);
      cnt     = sq_cnt + 12'd1;   // 12-bit wrap; a zero limit acts as one tick
      bit_now = sq_shift[sq_bit];
      case (sq_phase)
        PH_RST_LOW: begin
          if (cnt >= tcfg[REG_RESET_LOW]) begin
            sq_phase = PH_RST_REL;
            cnt = '0;
          end
        end
        PH_RST_REL: begin
          if (cnt >= tcfg[REG_PRESENCE_SAMP]) begin
            sq_pres  = !line;   // device answers by pulling low
            sq_phase = PH_RST_TAIL;
            cnt = '0;
          end
        end
        PH_RST_TAIL: begin
          // reset ends on its last tail tick, no recovery
          if (cnt >= tcfg[REG_RESET_TAIL]) begin
            sq_phase = PH_IDLE;
            cnt = '0;
            r.done = 1'b1;
          end
        end
        PH_SLOT_LOW: begin
          if (sq_op == OP_READ) lim = tcfg[REG_READ_LOW];
          else lim = bit_now ? tcfg[REG_WRITE_ONE_LOW] : tcfg[REG_WRITE_SLOT];
          if (cnt >= lim) begin
            // a written zero skips the released part
            sq_phase = (sq_op == OP_WRITE && !bit_now) ? PH_RECOVER : PH_SLOT_HIGH;
            cnt = '0;
          end
        end
        PH_SLOT_HIGH: begin
          if (sq_op == OP_READ && sq_cnt == 12'd0) sq_shift[sq_bit] = sq_shift[sq_bit] | line;
          lim = (sq_op == OP_READ) ? tcfg[REG_READ_WAIT] : tcfg[REG_WRITE_SLOT];
          if (cnt >= lim) begin
            sq_phase = PH_RECOVER;
            cnt = '0;
          end
        end
        default: begin
          cnt = '0;
          if (sq_bit == 3'd7) begin
            sq_phase = PH_IDLE;
            r.done = 1'b1;
            if (sq_op == OP_READ) sq_rx = sq_shift;
          end else begin
            sq_bit = sq_bit + 3'd1;
            sq_phase = PH_SLOT_LOW;
          end
        end
      endcase
      sq_cnt = cnt;
    end
    if (r.done) n_done++;
    r.pres = sq_pres;
    r.rx   = sq_rx;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: offers queued tick beats, idles in random bursts.
  // ---------------------------------------------------------------------------
  int in_gap = 0;

  always @(posedge clk) begin : driver
    tick_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_gap   <= 0;
    end else begin
      if (in_valid && in_ready) begin
        bus_out_q.push_back(step_bus_master(op_t'(in_cmd), in_tx_byte, in_line_level));
        n_beats++;
      end
      // slot is free once the current beat is gone
      if (!in_valid || in_ready) begin
        if (in_gap != 0 && !calm) begin
          in_gap   <= in_gap - 1;
          in_valid <= 1'b0;
        end else if (!calm && $urandom_range(0, 9) == 0) begin
          in_gap   <= $urandom_range(0, 15);
          in_valid <= 1'b0;
        end else if (bus_ticks_q.size() != 0) begin
          nxt = bus_ticks_q.pop_front();
          in_valid      <= 1'b1;
          in_cmd        <= nxt.op;
          in_tx_byte    <= nxt.tx_byte;
          in_line_level <= nxt.line_level;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: checks each result beat, stalls in random bursts, and once holds
  // off long enough to back the block up into in_ready.
  // ---------------------------------------------------------------------------
  int stall_left = 0;
  int hold_left = 0;

  task automatic cmp_field(input string fname, input int want_v, input int got_v);
    if (want_v != got_v) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, fname, want_v, got_v);
      n_errors++;
    end
  endtask

  always @(posedge clk) begin : monitor
    bus_out_t want;
    if (!rst_n) begin
      out_ready  <= 1'b0;
      stall_left <= 0;
      hold_left  <= 0;
    end else begin
      if (out_valid && out_ready) begin
        n_results++;
        if (bus_out_q.size() == 0) begin
          $display("%0t: unexpected result beat, expected none, actual drive=%0b busy=%0b",
                   $time, out_drive_low, out_busy_res);
          n_errors++;
        end else begin
          want = bus_out_q.pop_front();
          cmp_field("drive_low", want.drive, out_drive_low);
          cmp_field("busy_res", want.busy, out_busy_res);
          cmp_field("done_res", want.done, out_done_res);
          cmp_field("presence", want.pres, out_presence);
          cmp_field("rx_byte", want.rx, out_rx_byte);
        end
      end
      if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        out_ready <= 1'b0;
      end else if (hold_req && !hold_done) begin
        hold_done <= 1'b1;
        hold_left <= LONG_HOLD - 1;
        out_ready <= 1'b0;
      end else if (stall_left != 0 && !calm) begin
        stall_left <= stall_left - 1;
        out_ready  <= 1'b0;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        stall_left <= $urandom_range(0, 15);
        out_ready  <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  task automatic push_tick(input op_t c, input logic [7:0] tx, input logic line);
    tick_t t;
    t.op         = c;
    t.tx_byte    = tx;
    t.line_level = line;
    bus_ticks_q.push_back(t);
  endtask

  // plain ticks with random payload, no command
  task automatic push_idle(input int n);
    repeat (n) push_tick(OP_NONE, 8'($urandom), 1'($urandom_range(0, 1)));
  endtask

  // block is quiet: everything offered, taken and answered
  task automatic drain;
    @(posedge clk);
    while (bus_ticks_q.size() != 0 || in_valid || bus_out_q.size() != 0) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [2:0] idx, input logic [11:0] v);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    if (idx <= 3'(REG_READ_WAIT)) tcfg[idx] = v;
  endtask

  task automatic cfg_close;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    n_settings++;
  endtask

  task automatic cfg_all(input logic [11:0] v);
    for (int i = 0; i <= int'(REG_READ_WAIT); i++) cfg_write(3'(i), v);
    cfg_close();
  endtask

  initial begin : stim
    logic [11:0] v;
    int          pick;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Power-up timing: one all-ones write, long enough to finish (8 x 52 ticks)
    push_tick(OP_WRITE, 8'hFF, 1'b1);
    push_idle(419);
    drain();

    // Directed, all times one tick
    cfg_all(12'd1);
    push_tick(OP_NONE, 8'hFF, 1'b0);
    push_tick(OP_NONE, 8'h00, 1'b1);
    push_tick(OP_RESET, 8'h00, 1'b1);  // start tick drives low
    push_tick(OP_WRITE, 8'hFF, 1'b0);  // presence sample, device answers; cmd ignored
    push_tick(OP_READ, 8'h00, 1'b1);   // done tick, cmd still ignored
    push_tick(OP_WRITE, 8'h00, 1'b1);  // all zeros: low then recovery per bit
    for (int i = 0; i < 15; i++) push_tick(op_t'(1 + i % 3), 8'hFF, 1'b0);  // busy, ignored
    push_tick(OP_RESET, 8'h00, 1'b0);  // reset with nobody answering
    push_tick(OP_NONE, 8'h00, 1'b1);
    push_tick(OP_NONE, 8'h00, 1'b1);
    drain();

    // Stray register index leaves the one-tick times alone; a read shows it
    cfg_write(REG_UNUSED, 12'($urandom));
    cfg_close();
    push_tick(OP_READ, 8'h00, 1'b1);
    push_idle(29);
    drain();

    // Random settings and random ticks; zero times in one pass, long hold-off in
    // another, no idling in the last
    for (int k = 0; k < 7; k++) begin
      if (k == 2) begin
        cfg_all(12'd0);
      end else begin
        for (int i = 0; i <= int'(REG_READ_WAIT); i++) begin
          pick = $urandom_range(0, 9);
          if (pick == 0) v = 12'd0;
          else if (pick == 1) v = 12'($urandom_range(7, 24));
          else v = 12'($urandom_range(1, 5));
          cfg_write(3'(i), v);
        end
        cfg_close();
      end
      if (k == 6) calm = 1'b1;
      for (int j = 0; j < 140; j++) begin
        if ($urandom_range(0, 4) == 0)
          push_tick(op_t'($urandom_range(1, 3)), 8'($urandom), 1'($urandom_range(0, 1)));
        else
          push_tick(OP_NONE, 8'($urandom), 1'($urandom_range(0, 1)));
      end
      if (k == 1) hold_req = 1'b1;
      drain();
    end

    repeat (8) @(posedge clk);
    if (bus_out_q.size() != 0) begin
      $display("%0t: %0d expected result beats never arrived", $time, bus_out_q.size());
      n_errors++;
    end
    $display("Ran %0d tick beats (%0d results) over %0d timing settings.",
             n_beats, n_results, n_settings);
    $display("Started %0d resets, %0d byte writes, %0d byte reads; %0d completed.",
             n_start[OP_RESET], n_start[OP_WRITE], n_start[OP_READ], n_done);
    if (n_errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #25_000_000;
    $display("Timeout after %0d tick beats", n_beats);
    $display("*** FAILED ***");
    $finish;
  end

endmodule

FILE: one_wire_master_top.f
hdl/owm_pkg.sv
hdl/owm_front.sv
hdl/owm_queue.sv
hdl/owm_back.sv
hdl/one_wire_master_top.sv
sim/tb_one_wire_master_top.sv
